// File: hw/rtl/seek_point_accel_command_unit_macros.svh
// Assertion macros used by the seek point acceleration command unit top level.
`ifndef SEEK_POINT_ACCEL_COMMAND_UNIT_MACROS_SVH
`define SEEK_POINT_ACCEL_COMMAND_UNIT_MACROS_SVH

// a implies that b holds later
`define SPA_ASSERT_DELAY(lbl, a, n, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> ##(n) (b)) \
    else $error(msg);

// a implies that b held earlier
`define SPA_ASSERT_PAST(lbl, a, n, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> $past(b, n)) \
    else $error(msg);

`endif

// File: hw/rtl/spa_pkg.sv
// Types, widths and helper functions of the seek point acceleration command unit.
`default_nettype none
package spa_pkg;

  localparam int CFG_IDX_W = 2;

  localparam int SQ_IN_W   = 65;
  localparam int SQ_ROOT_W = 33;
  localparam int SQ_REM_W  = SQ_IN_W + 2;
  localparam int SQ_LAT    = SQ_ROOT_W;

  localparam int DV_DEN_W  = 33;
  localparam int DV_Q_W    = 32;
  localparam int DV_NUM_W  = DV_DEN_W + DV_Q_W;
  localparam int DV_LAT    = DV_Q_W + 1;

  localparam int TOTAL_LAT = 4 + SQ_LAT + 1 + DV_LAT + 3 + SQ_LAT + DV_LAT + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_X    = 2'd0,
    CFG_TARGET_Y    = 2'd1,
    CFG_SPEED_LIMIT = 2'd2,
    CFG_SMALL_THR   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               lt;
    logic               zlen;
  } front_t;

  typedef struct packed {
    logic signed [32:0] ax;
    logic signed [32:0] ay;
    logic               proj;
    logic               dot_neg;
    logic               crs_neg;
    logic [64:0]        dot_mag;
    logic [64:0]        crs_mag;
  } back_t;

  typedef struct packed {
    logic signed [32:0] ax;
    logic signed [32:0] ay;
    logic               proj;
    logic               dot_neg;
    logic               crs_neg;
  } tail_t;

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    logic [31:0] m;
    m = v[31] ? 32'(-v) : 32'(v);
    return m;
  endfunction

  // operand magnitude stays below 2^32
  function automatic logic [31:0] mag33(logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    return m[31:0];
  endfunction

  function automatic logic signed [65:0] sgn66(logic neg, logic [63:0] p);
    logic signed [65:0] s;
    s = $signed({2'b00, p});
    return neg ? -s : s;
  endfunction

  function automatic logic [64:0] mag66(logic signed [65:0] v);
    logic [65:0] m;
    m = v[65] ? 66'(-v) : 66'(v);
    return m[64:0];
  endfunction

  function automatic logic [31:0] sat33(logic signed [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_quo(logic neg, logic [31:0] q);
    logic [31:0] r;
    if (q[31]) begin
      r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = neg ? (~q + 32'd1) : q;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/spa_sqrt.sv
// Pipelined floor square root, one result bit per stage.
`default_nettype none
module spa_sqrt (
  input  logic                         clk_i,
  input  logic [spa_pkg::SQ_IN_W-1:0]  rad_i,
  output logic [spa_pkg::SQ_ROOT_W-1:0] root_o
);

  localparam int RemW  = spa_pkg::SQ_REM_W;
  localparam int RootW = spa_pkg::SQ_ROOT_W;
  localparam int Lat   = spa_pkg::SQ_LAT;

  logic [RemW-1:0]  rem_q  [Lat];
  logic [RootW-1:0] root_q [Lat];

  for (genvar k = 0; k < Lat; k++) begin : g_step
    localparam int Bit = RootW - 1 - k;
    logic [RemW-1:0]  rem_in;
    logic [RemW-1:0]  trial;
    logic [RootW-1:0] root_in;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in  = RemW'(rad_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // (r + 2^b)^2 - r^2
    assign trial = (RemW'(root_in) << (Bit + 1)) | (RemW'(1) << (2 * Bit));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? rem_in - trial : rem_in;
      root_q[k] <= take ? (root_in | (RootW'(1) << Bit)) : root_in;
    end
  end

  assign root_o = root_q[Lat-1];

endmodule
`default_nettype wire

// File: hw/rtl/spa_div.sv
// Pipelined restoring divider with a 32-bit quotient that reads all ones on overflow.
`default_nettype none
module spa_div (
  input  logic                          clk_i,
  input  logic [spa_pkg::DV_NUM_W-1:0]  num_i,
  input  logic [spa_pkg::DV_DEN_W-1:0]  den_i,
  output logic [spa_pkg::DV_Q_W-1:0]    quo_o
);

  localparam int NumW = spa_pkg::DV_NUM_W;
  localparam int DenW = spa_pkg::DV_DEN_W;
  localparam int QW   = spa_pkg::DV_Q_W;
  localparam int Lat  = spa_pkg::DV_LAT;

  logic [NumW-1:0] rem_q [Lat];
  logic [DenW-1:0] den_q [Lat];
  logic [QW-1:0]   quo_q [Lat];
  logic            ovf_q [Lat];

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    ovf_q[0] <= num_i >= {den_i, {QW{1'b0}}};
  end

  for (genvar k = 1; k < Lat; k++) begin : g_step
    localparam int Bit = QW - k;
    logic [NumW-1:0] sub;
    logic            take;

    assign sub  = NumW'(den_q[k-1]) << Bit;
    assign take = rem_q[k-1] >= sub;

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? rem_q[k-1] - sub : rem_q[k-1];
      den_q[k] <= den_q[k-1];
      quo_q[k] <= take ? (quo_q[k-1] | (QW'(1) << Bit)) : quo_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
    end
  end

  assign quo_o = ovf_q[Lat-1] ? '1 : quo_q[Lat-1];

endmodule
`default_nettype wire

// File: hw/rtl/seek_point_accel_command_unit.sv
// Top level of the seek point acceleration command unit.
// A measurement beat is taken at every clock edge with start high; busy never rises.
// Each beat yields one result, shown for one cycle with done_o high; the receiver
// cannot stall, so results leave in order at the input rate. The pipeline runs through
// two pipelined square roots and two pairs of pipelined dividers, one result bit per
// stage. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i.
`default_nettype none
`include "seek_point_accel_command_unit_macros.svh"
module seek_point_accel_command_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cfg_we_i,
  input  logic [spa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic signed [31:0]             pos_x_i,
  input  logic signed [31:0]             pos_y_i,
  input  logic signed [31:0]             vel_x_i,
  input  logic signed [31:0]             vel_y_i,
  output logic                           done_o,
  output logic signed [31:0]             accel_tangential_o,
  output logic signed [31:0]             accel_radial_o,
  output logic                           fallback_used_o
);

  localparam int SqLat   = spa_pkg::SQ_LAT;
  localparam int DvLat   = spa_pkg::DV_LAT;
  localparam int TailLat = 2 + SqLat + DvLat + 1;

  // configuration
  logic signed [31:0] target_x_q, target_y_q;
  logic [30:0]        speed_limit_q, small_thr_q;
  logic [61:0]        lim2_q, thr2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_x_q    <= '0;
      target_y_q    <= '0;
      speed_limit_q <= 31'd65536;
      small_thr_q   <= 31'd66;
    end else if (cfg_we_i) begin
      unique case (spa_pkg::cfg_idx_e'(cfg_idx_i))
        spa_pkg::CFG_TARGET_X:    target_x_q    <= cfg_data_i;
        spa_pkg::CFG_TARGET_Y:    target_y_q    <= cfg_data_i;
        spa_pkg::CFG_SPEED_LIMIT: speed_limit_q <= cfg_data_i[30:0];
        spa_pkg::CFG_SMALL_THR:   small_thr_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    lim2_q <= speed_limit_q * speed_limit_q;
    thr2_q <= small_thr_q * small_thr_q;
  end

  assign busy = 1'b0;

  // valid bits
  logic             v_a_q, v_b_q, v_c_q, v_d_q, v_f_q, v_g_q, v_h_q, v_i_q, done_q;
  logic [SqLat-1:0] v1_q, v3_q;
  logic [DvLat-1:0] v2_q, v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q  <= 1'b0;
      v_b_q  <= 1'b0;
      v_c_q  <= 1'b0;
      v_d_q  <= 1'b0;
      v1_q   <= '0;
      v_f_q  <= 1'b0;
      v2_q   <= '0;
      v_g_q  <= 1'b0;
      v_h_q  <= 1'b0;
      v_i_q  <= 1'b0;
      v3_q   <= '0;
      v4_q   <= '0;
      done_q <= 1'b0;
    end else begin
      v_a_q  <= start && !busy;
      v_b_q  <= v_a_q;
      v_c_q  <= v_b_q;
      v_d_q  <= v_c_q;
      v1_q   <= {v1_q[SqLat-2:0], v_d_q};
      v_f_q  <= v1_q[SqLat-1];
      v2_q   <= {v2_q[DvLat-2:0], v_f_q};
      v_g_q  <= v2_q[DvLat-1];
      v_h_q  <= v_g_q;
      v_i_q  <= v_h_q;
      v3_q   <= {v3_q[SqLat-2:0], v_i_q};
      v4_q   <= {v4_q[DvLat-2:0], v3_q[SqLat-1]};
      done_q <= v4_q[DvLat-1];
    end
  end

  // stage A: input beat
  logic signed [31:0] px_a_q, py_a_q, vx_a_q, vy_a_q;

  always_ff @(posedge clk_i) begin
    px_a_q <= pos_x_i;
    py_a_q <= pos_y_i;
    vx_a_q <= vel_x_i;
    vy_a_q <= vel_y_i;
  end

  // stage B: offset to target
  spa_pkg::front_t fr_b_q, fr_c_q, fr_d_q;

  always_ff @(posedge clk_i) begin
    fr_b_q.dx   <= $signed({target_x_q[31], target_x_q}) - $signed({px_a_q[31], px_a_q});
    fr_b_q.dy   <= $signed({target_y_q[31], target_y_q}) - $signed({py_a_q[31], py_a_q});
    fr_b_q.vx   <= vx_a_q;
    fr_b_q.vy   <= vy_a_q;
    fr_b_q.lt   <= 1'b0;
    fr_b_q.zlen <= 1'b0;
  end

  // stage C: squares of the offset
  logic [31:0] dmx_b, dmy_b;
  logic [63:0] dsq_x_c_q, dsq_y_c_q;

  assign dmx_b = spa_pkg::mag33(fr_b_q.dx);
  assign dmy_b = spa_pkg::mag33(fr_b_q.dy);

  always_ff @(posedge clk_i) begin
    dsq_x_c_q <= dmx_b * dmx_b;
    dsq_y_c_q <= dmy_b * dmy_b;
    fr_c_q    <= fr_b_q;
  end

  // stage D: squared distance
  logic [64:0] dist2_d_q;

  always_ff @(posedge clk_i) begin
    dist2_d_q <= 65'(dsq_x_c_q) + 65'(dsq_y_c_q);
    fr_d_q    <= fr_c_q;
  end

  // distance root, side data beside it
  logic [32:0]     len_s;
  spa_pkg::front_t side1_q [SqLat];
  spa_pkg::front_t side1_in;

  spa_sqrt u_sqrt_dist (
    .clk_i  (clk_i),
    .rad_i  (dist2_d_q),
    .root_o (len_s)
  );

  always_comb begin
    side1_in    = fr_d_q;
    side1_in.lt = dist2_d_q < 65'(lim2_q);
  end

  always_ff @(posedge clk_i) begin
    side1_q[0] <= side1_in;
    for (int k = 1; k < SqLat; k++) begin
      side1_q[k] <= side1_q[k-1];
    end
  end

  // stage F: rescale numerators
  spa_pkg::front_t fr_f_q;
  spa_pkg::front_t fr_e;
  logic [64:0]     num_x_f_q, num_y_f_q;
  logic [32:0]     len_f_q;
  logic [31:0]     dmx_e, dmy_e;
  logic [62:0]     prod_x_e, prod_y_e;

  assign dmx_e    = spa_pkg::mag33(side1_q[SqLat-1].dx);
  assign dmy_e    = spa_pkg::mag33(side1_q[SqLat-1].dy);
  assign prod_x_e = dmx_e * speed_limit_q;
  assign prod_y_e = dmy_e * speed_limit_q;

  always_comb begin
    fr_e      = side1_q[SqLat-1];
    fr_e.zlen = len_s == '0;
  end

  always_ff @(posedge clk_i) begin
    num_x_f_q <= {2'b00, prod_x_e};
    num_y_f_q <= {2'b00, prod_y_e};
    len_f_q   <= len_s;
    fr_f_q    <= fr_e;
  end

  logic [31:0]     qx_s, qy_s;
  spa_pkg::front_t side2_q [DvLat];

  spa_div u_div_x (
    .clk_i (clk_i),
    .num_i (num_x_f_q),
    .den_i (len_f_q),
    .quo_o (qx_s)
  );

  spa_div u_div_y (
    .clk_i (clk_i),
    .num_i (num_y_f_q),
    .den_i (len_f_q),
    .quo_o (qy_s)
  );

  always_ff @(posedge clk_i) begin
    side2_q[0] <= fr_f_q;
    for (int k = 1; k < DvLat; k++) begin
      side2_q[k] <= side2_q[k-1];
    end
  end

  // stage G: desired velocity and acceleration
  spa_pkg::front_t    fr2;
  logic signed [32:0] tvx, tvy;
  logic signed [32:0] ax_g_q, ay_g_q;
  logic signed [31:0] vx_g_q, vy_g_q;

  assign fr2 = side2_q[DvLat-1];

  always_comb begin
    if (fr2.lt) begin
      tvx = fr2.dx;
      tvy = fr2.dy;
    end else if (fr2.zlen) begin
      tvx = '0;
      tvy = '0;
    end else begin
      tvx = fr2.dx[32] ? -$signed({1'b0, qx_s}) : $signed({1'b0, qx_s});
      tvy = fr2.dy[32] ? -$signed({1'b0, qy_s}) : $signed({1'b0, qy_s});
    end
  end

  always_ff @(posedge clk_i) begin
    ax_g_q <= tvx - $signed({fr2.vx[31], fr2.vx});
    ay_g_q <= tvy - $signed({fr2.vy[31], fr2.vy});
    vx_g_q <= fr2.vx;
    vy_g_q <= fr2.vy;
  end

  // stage H: products
  logic [31:0]        vmx, vmy, amx, amy;
  logic [63:0]        vv_x_q, vv_y_q, aa_x_q, aa_y_q;
  logic [63:0]        p_vxax_q, p_vyay_q, p_vyax_q, p_vxay_q;
  logic               n_vxax_q, n_vyay_q, n_vyax_q, n_vxay_q;
  logic signed [32:0] ax_h_q, ay_h_q;

  assign vmx = spa_pkg::mag32(vx_g_q);
  assign vmy = spa_pkg::mag32(vy_g_q);
  assign amx = spa_pkg::mag33(ax_g_q);
  assign amy = spa_pkg::mag33(ay_g_q);

  always_ff @(posedge clk_i) begin
    vv_x_q   <= vmx * vmx;
    vv_y_q   <= vmy * vmy;
    aa_x_q   <= amx * amx;
    aa_y_q   <= amy * amy;
    p_vxax_q <= vmx * amx;
    p_vyay_q <= vmy * amy;
    p_vyax_q <= vmy * amx;
    p_vxay_q <= vmx * amy;
    n_vxax_q <= vx_g_q[31] ^ ax_g_q[32];
    n_vyay_q <= vy_g_q[31] ^ ay_g_q[32];
    n_vyax_q <= vy_g_q[31] ^ ax_g_q[32];
    n_vxay_q <= vx_g_q[31] ^ ay_g_q[32];
    ax_h_q   <= ax_g_q;
    ay_h_q   <= ay_g_q;
  end

  // stage I: sums of squares, dot and cross
  logic [63:0]        spd2_i_q;
  logic [64:0]        acc2_i_q;
  logic signed [65:0] dot_i_q, crs_i_q;
  logic signed [32:0] ax_i_q, ay_i_q;

  always_ff @(posedge clk_i) begin
    spd2_i_q <= vv_x_q + vv_y_q;
    acc2_i_q <= 65'(aa_x_q) + 65'(aa_y_q);
    dot_i_q  <= spa_pkg::sgn66(n_vxax_q, p_vxax_q) + spa_pkg::sgn66(n_vyay_q, p_vyay_q);
    crs_i_q  <= spa_pkg::sgn66(n_vyax_q, p_vyax_q) - spa_pkg::sgn66(n_vxay_q, p_vxay_q);
    ax_i_q   <= ax_h_q;
    ay_i_q   <= ay_h_q;
  end

  // speed root, side data beside it
  logic [32:0]    spd_s;
  spa_pkg::back_t side3_q [SqLat];
  spa_pkg::back_t side3_in;

  spa_sqrt u_sqrt_speed (
    .clk_i  (clk_i),
    .rad_i  (65'(spd2_i_q)),
    .root_o (spd_s)
  );

  always_comb begin
    side3_in.ax      = ax_i_q;
    side3_in.ay      = ay_i_q;
    side3_in.proj    = (62'(spd2_i_q) > thr2_q || spd2_i_q[63:62] != 2'b00)
                       && (acc2_i_q > 65'(thr2_q));
    side3_in.dot_neg = dot_i_q[65];
    side3_in.crs_neg = crs_i_q[65];
    side3_in.dot_mag = spa_pkg::mag66(dot_i_q);
    side3_in.crs_mag = spa_pkg::mag66(crs_i_q);
  end

  always_ff @(posedge clk_i) begin
    side3_q[0] <= side3_in;
    for (int k = 1; k < SqLat; k++) begin
      side3_q[k] <= side3_q[k-1];
    end
  end

  // projections
  logic [31:0]    qd_s, qc_s;
  spa_pkg::tail_t side4_q [DvLat];
  spa_pkg::tail_t side4_in;

  spa_div u_div_dot (
    .clk_i (clk_i),
    .num_i (side3_q[SqLat-1].dot_mag),
    .den_i (spd_s),
    .quo_o (qd_s)
  );

  spa_div u_div_cross (
    .clk_i (clk_i),
    .num_i (side3_q[SqLat-1].crs_mag),
    .den_i (spd_s),
    .quo_o (qc_s)
  );

  always_comb begin
    side4_in.ax      = side3_q[SqLat-1].ax;
    side4_in.ay      = side3_q[SqLat-1].ay;
    side4_in.proj    = side3_q[SqLat-1].proj;
    side4_in.dot_neg = side3_q[SqLat-1].dot_neg;
    side4_in.crs_neg = side3_q[SqLat-1].crs_neg;
  end

  always_ff @(posedge clk_i) begin
    side4_q[0] <= side4_in;
    for (int k = 1; k < DvLat; k++) begin
      side4_q[k] <= side4_q[k-1];
    end
  end

  // result register
  spa_pkg::tail_t tl;
  logic [31:0]    tan_q, rad_q;
  logic           fb_q;

  assign tl = side4_q[DvLat-1];

  always_ff @(posedge clk_i) begin
    tan_q <= tl.proj ? spa_pkg::sat_quo(tl.crs_neg, qc_s) : spa_pkg::sat33(tl.ax);
    rad_q <= tl.proj ? spa_pkg::sat_quo(tl.dot_neg, qd_s) : spa_pkg::sat33(tl.ay);
    fb_q  <= !tl.proj;
  end

  assign done_o             = done_q;
  assign accel_tangential_o = tan_q;
  assign accel_radial_o     = rad_q;
  assign fallback_used_o    = fb_q;

  `SPA_ASSERT_DELAY(a_beat_to_result, start && !busy, spa_pkg::TOTAL_LAT, done_o, "result beat missing")
  `SPA_ASSERT_PAST(a_result_has_beat, done_o, spa_pkg::TOTAL_LAT, start, "result beat without input")
  `SPA_ASSERT_DELAY(a_tail_latency, v_g_q, TailLat, done_o, "tail pipeline lost a beat")

endmodule
`default_nettype wire

// File: test/seek_point_accel_command_unit_tb.sv
// Testbench for the seek point acceleration command unit: directed and random stimulus, in-bench predictor.
`default_nettype none
module seek_point_accel_command_unit_tb;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
  } meas_t;

  typedef struct packed {
    logic [31:0] tang;
    logic [31:0] rad;
    logic        fb;
  } cmd_t;

  localparam int LATENCY   = 141;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1700;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we_i = 1'b0;
  logic [spa_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, vel_x_i = '0, vel_y_i = '0;
  logic        done_o;
  logic signed [31:0] accel_tangential_o, accel_radial_o;
  logic        fallback_used_o;

  seek_point_accel_command_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic signed [31:0] tgt_x = '0, tgt_y = '0;
  logic [30:0] spd_lim = 31'd65536, thr = 31'd66;

  meas_t pending_meas[$];
  cmd_t  expected_cmds[$];
  int    errors = 0;
  int    n_accepted = 0;
  int    n_checked = 0;
  int    n_fallback = 0;
  int    idle_cycles = 0;
  int    gap = 0;
  bit    stim_done = 0;

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] r, c;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_sm(bit neg, logic [127:0] m);
    if (neg) return (m >= 128'h8000_0000) ? 32'h8000_0000 : 32'(-m);
    return (m > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(m);
  endfunction

  function automatic cmd_t predict_cmd(meas_t m);
    cmd_t c;
    longint dx, dy, tvx, tvy, ax, ay, vx, vy, len, spd;
    logic signed [127:0] dot, crs, d2, s2, a2;
    dx = longint'(tgt_x) - longint'($signed(m.px));
    dy = longint'(tgt_y) - longint'($signed(m.py));
    vx = longint'($signed(m.vx));
    vy = longint'($signed(m.vy));
    d2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
    if (d2 < 128'(spd_lim) * 128'(spd_lim)) begin
      tvx = dx;
      tvy = dy;
    end else begin
      len = longint'(isqrt(d2));
      if (len == 0) begin
        tvx = 0;
        tvy = 0;
      end else begin
        tvx = (dx < 0 ? -dx : dx) * longint'(spd_lim) / len;
        tvy = (dy < 0 ? -dy : dy) * longint'(spd_lim) / len;
        if (dx < 0) tvx = -tvx;
        if (dy < 0) tvy = -tvy;
      end
    end
    ax = tvx - vx;
    ay = tvy - vy;
    s2 = 128'(vx) * 128'(vx) + 128'(vy) * 128'(vy);
    a2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
    if (s2 > 128'(thr) * 128'(thr) && a2 > 128'(thr) * 128'(thr)) begin
      spd = longint'(isqrt(s2));
      dot = 128'(vx) * 128'(ax) + 128'(vy) * 128'(ay);
      crs = 128'(vy) * 128'(ax) - 128'(vx) * 128'(ay);
      c.rad  = sat_sm(dot < 0, (dot < 0 ? -dot : dot) / 128'(spd));
      c.tang = sat_sm(crs < 0, (crs < 0 ? -crs : crs) / 128'(spd));
      c.fb = 1'b0;
    end else begin
      c.tang = sat_sm(ax < 0, 128'(ax < 0 ? -ax : ax));
      c.rad  = sat_sm(ay < 0, 128'(ay < 0 ? -ay : ay));
      c.fb = 1'b1;
    end
    return c;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 400)) - 200);
      3: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      4: return {{12{$urandom_range(0,1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_cmds.push_back(predict_cmd({pos_x_i, pos_y_i, vel_x_i, vel_y_i}));
        n_accepted++;
      end
      if (start && busy) begin
        // hold
      end else if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (pending_meas.size() > 0) begin
        meas_t m;
        m = pending_meas.pop_front();
        {pos_x_i, pos_y_i, vel_x_i, vel_y_i} <= m;
        start <= 1'b1;
        case ($urandom_range(0, 9))
          0, 1, 2: gap = $urandom_range(1, 3);
          3: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 200) : 0;
          default: gap = 0;
        endcase
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected beat tang=%h rad=%h fb=%b", $time,
                 accel_tangential_o, accel_radial_o, fallback_used_o);
        errors++;
      end else begin
        cmd_t e;
        e = expected_cmds.pop_front();
        n_checked++;
        if (e.fb) n_fallback++;
        if (accel_tangential_o !== e.tang) begin
          $display("%0t: tangential exp %h got %h", $time, e.tang, accel_tangential_o);
          errors++;
        end
        if (accel_radial_o !== e.rad) begin
          $display("%0t: radial exp %h got %h", $time, e.rad, accel_radial_o);
          errors++;
        end
        if (fallback_used_o !== e.fb) begin
          $display("%0t: fallback exp %b got %b", $time, e.fb, fallback_used_o);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_we_i || stim_done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("seek_point_accel_command_unit regression: fail");
      $finish;
    end
  end

  task automatic write_reg(spa_pkg::cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      spa_pkg::CFG_TARGET_X:    tgt_x = val;
      spa_pkg::CFG_TARGET_Y:    tgt_y = val;
      spa_pkg::CFG_SPEED_LIMIT: spd_lim = val[30:0];
      spa_pkg::CFG_SMALL_THR:   thr = val[30:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_meas.size() > 0 || expected_cmds.size() > 0 || start || gap > 0)
      @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic add_meas(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                          logic [31:0] vy);
    pending_meas.push_back({px, py, vx, vy});
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, zero offset, slow and fast, fallback and projection
    add_meas(0, 0, 0, 0);
    add_meas(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_meas(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_meas(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    add_meas(32'h0000_8000, 0, 32'h0001_0000, 0);
    add_meas(32'hFFFF_0000, 32'h0002_0000, 0, 32'h0000_0040);
    add_meas(32'h0010_0000, 32'hFFF0_0000, 32'hFFFF_F000, 32'h0000_1000);
    add_meas(0, 0, 32'h0000_0042, 0);
    add_meas(0, 0, 32'h0000_0043, 0);
    add_meas(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    // zero speed limit with zero offset
    write_reg(spa_pkg::CFG_TARGET_X, 32'h7FFF_FFFF);
    write_reg(spa_pkg::CFG_TARGET_Y, 32'h8000_0000);
    write_reg(spa_pkg::CFG_SPEED_LIMIT, 0);
    write_reg(spa_pkg::CFG_SMALL_THR, 0);
    add_meas(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_1000, 32'hFFFF_0000);
    add_meas(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    add_meas(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    add_meas(0, 0, 32'h8000_0000, 32'h8000_0000);
    drain();
    write_reg(spa_pkg::CFG_SPEED_LIMIT, 32'hFFFF_FFFF);
    write_reg(spa_pkg::CFG_SMALL_THR, 32'hFFFF_FFFF);
    add_meas(0, 0, 32'h8000_0000, 32'h8000_0000);
    add_meas(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_meas(32'h1234_5678, 32'h8765_4321, 32'h0000_1000, 32'h0000_2000);
    drain();
    // random phases with a fresh setting each time
    for (int ph = 0; ph < 17; ph++) begin
      write_reg(spa_pkg::CFG_TARGET_X, rand_word());
      write_reg(spa_pkg::CFG_TARGET_Y, rand_word());
      case ($urandom_range(0, 3))
        0: write_reg(spa_pkg::CFG_SPEED_LIMIT, $urandom_range(0, 32'h0004_0000));
        1: write_reg(spa_pkg::CFG_SPEED_LIMIT, 32'h7FFF_FFFF);
        default: write_reg(spa_pkg::CFG_SPEED_LIMIT, $urandom);
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(spa_pkg::CFG_SMALL_THR, 0);
        1: write_reg(spa_pkg::CFG_SMALL_THR, $urandom);
        default: write_reg(spa_pkg::CFG_SMALL_THR, $urandom_range(0, 32'h0002_0000));
      endcase
      for (int i = 0; i < N_RANDOM / 17; i++) begin
        if ($urandom_range(0, 3) == 0)
          add_meas(tgt_x + $urandom_range(0, 200) - 100, tgt_y + $urandom_range(0, 200) - 100,
                   rand_word(), rand_word());
        else
          add_meas(rand_word(), rand_word(), rand_word(), rand_word());
      end
      drain();
    end
    stim_done = 1;
    $display("Checked %0d results of %0d measurements, %0d in fallback.", n_checked,
             n_accepted, n_fallback);
    if (errors == 0) begin
      $display("seek_point_accel_command_unit regression: pass");
    end else begin
      $display("seek_point_accel_command_unit regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
